@@ hdl/bla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_pkg
// Shared types and constants of the bitmap line allocator.
// ----------------------------------------------------------------------------
package bla_pkg;

  // Field widths of the request and result items.
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 10;

  // Bits of the used map held in one memory word.
  localparam int WORD_W = 8;
  localparam int BIT_W  = 3;

  // Largest number of lines the result value can name.
  localparam int VALUE_SPAN = 1024;

  // Request kinds.
  typedef enum logic [OP_W-1:0] {
    OP_FIND    = 2'd0,
    OP_RESERVE = 2'd1,
    OP_SET     = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;

  // Register map.
  localparam logic REG_ACTIVE_UNITS = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RES_RD,
    S_RES_LOAD,
    S_RES_EMIT,
    S_SETCLR,
    S_REPLY
  } state_t;

endpackage

@@ hdl/bla_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/bitmap_line_allocator_core.sv @@
`timescale 1ns / 1ps
// Sequence: set and clear read the addressed word and write it back, then reply;
// find scans word by word until a run fits or the last word; reserve counts free
// lines, then visits words again through S_RES_RD, S_RES_LOAD and S_RES_EMIT.
// Throughput: one request at a time, bounded by the single read port of the map.
// Reset: the map is cleared by a pass of one word per cycle during which no item
// is accepted; active_units resets to 1024.
// ----------------------------------------------------------------------------
// bitmap_line_allocator_core
// First-fit allocator over a used/free bitmap kept in a word-wide RAM.
// ----------------------------------------------------------------------------
module bitmap_line_allocator_core
  import bla_pkg::*;
#(
  parameter int LINES       = 1024,
  parameter int MAX_RESERVE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [10:0] count, [20:11] index, [23:21] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] status, [11:2] value, [15:12] zero
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EFF_LINES = (LINES < VALUE_SPAN) ? LINES : VALUE_SPAN;
  localparam int DEPTH     = (EFF_LINES + WORD_W - 1) / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW        = $clog2(MAX_RESERVE + 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

  state_t state, state_next;

  // Configuration.
  logic [COUNT_W-1:0] active_units;
  logic [COUNT_W-1:0] n_lines;

  // Request registers.
  op_t                op_r;
  logic [COUNT_W-1:0] count_r;
  logic [INDEX_W-1:0] idx_r;

  // Sequencer datapath registers.
  logic [AW-1:0]       word, word_next;
  logic [COUNT_W-1:0]  run, run_next;
  logic [COUNT_W-1:0]  avail, avail_next;
  logic [RW-1:0]       remaining, remaining_next;
  logic [WORD_W-1:0]   cur, cur_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [VALUE_W-1:0]  res_value, res_value_next;

  // Output register.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_value;
  logic                out_last;
  logic                out_free;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [VALUE_W-1:0]  emit_value;
  logic                emit_last;

  // Memory ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Per-word analysis.
  logic [COUNT_W-1:0] word_base;
  logic [WORD_W-1:0]  active_mask;
  logic [WORD_W-1:0]  free_bits;
  logic [BIT_W:0]     free_pop;
  logic [COUNT_W-1:0] scan_run;
  logic               scan_found;
  logic [COUNT_W-1:0] scan_base;
  logic [COUNT_W-1:0] avail_sum;
  logic [WORD_W-1:0]  cur_active;
  logic [WORD_W-1:0]  cur_free;
  logic [BIT_W-1:0]   cur_sel;

  logic               in_accept;
  logic [AW-1:0]      idx_word;
  logic               idx_active;
  op_t                in_op;
  logic [COUNT_W-1:0] in_count;
  logic [INDEX_W-1:0] in_index;

  assign in_op     = op_t'(s_axis_tuser);
  assign in_count  = s_axis_tdata[COUNT_W-1:0];
  assign in_index  = s_axis_tdata[COUNT_W+INDEX_W-1:COUNT_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // Number of lines that take part in searches.
  assign n_lines = (active_units > COUNT_W'(EFF_LINES)) ? COUNT_W'(EFF_LINES) : active_units;

  assign idx_word   = AW'(idx_r[INDEX_W-1:BIT_W]);
  assign idx_active = ({1'b0, idx_r} < n_lines);

  // Configuration register write and read.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_units <= COUNT_W'(VALUE_SPAN);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_UNITS)) begin
      active_units <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACTIVE_UNITS) begin
      prdata = {{(32-COUNT_W){1'b0}}, active_units};
    end
  end

  // Bitmap storage.
  bla_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Active lines and free lines in the word just read.
  assign word_base = COUNT_W'({word, {BIT_W{1'b0}}});
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      active_mask[b] = ((word_base + COUNT_W'(b)) < n_lines);
    end
  end
  assign free_bits = ~ram_rdata & active_mask;

  always_comb begin
    free_pop = '0;
    for (int b = 0; b < WORD_W; b++) begin
      free_pop = free_pop + (BIT_W+1)'(free_bits[b]);
    end
  end
  assign avail_sum = avail + COUNT_W'(free_pop);

  // Run tracking across the eight lines of the word for a contiguous search.
  always_comb begin
    scan_run   = run;
    scan_found = 1'b0;
    scan_base  = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (free_bits[b]) begin
        scan_run = scan_run + COUNT_W'(1);
        if (!scan_found && (scan_run == count_r)) begin
          scan_found = 1'b1;
          scan_base  = word_base + COUNT_W'(b) + COUNT_W'(1) - count_r;
        end
      end else begin
        scan_run = '0;
      end
    end
  end

  // Lowest free active line in the word held for reservation.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cur_active[b] = ((word_base + COUNT_W'(b)) < n_lines);
    end
  end
  assign cur_free = ~cur & cur_active;
  always_comb begin
    cur_sel = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cur_free[b]) begin
        cur_sel = BIT_W'(b);
      end
    end
  end

  assign out_free = !out_valid || m_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (word == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_FIND: begin
              state_next = (in_count == '0) ? S_REPLY : S_SCAN;
            end
            OP_RESERVE: begin
              if ((in_count > COUNT_W'(MAX_RESERVE)) || (in_count == '0)) begin
                state_next = S_REPLY;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_SETCLR;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (op_r == OP_FIND) begin
          if (scan_found || (word == LAST_WORD)) begin
            state_next = S_REPLY;
          end
        end else if (avail_sum >= count_r) begin
          state_next = S_RES_RD;
        end else if (word == LAST_WORD) begin
          state_next = S_REPLY;
        end
      end
      S_RES_RD: begin
        state_next = S_RES_LOAD;
      end
      S_RES_LOAD: begin
        state_next = S_RES_EMIT;
      end
      S_RES_EMIT: begin
        if ((remaining == '0) || (cur_free == '0)) begin
          state_next = (remaining == '0) ? S_IDLE : S_RES_RD;
        end
      end
      S_SETCLR: begin
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath, memory and result controls.
  always_comb begin
    word_next       = word;
    run_next        = run;
    avail_next      = avail;
    remaining_next  = remaining;
    cur_next        = cur;
    res_status_next = res_status;
    res_value_next  = res_value;
    ram_we          = 1'b0;
    ram_waddr       = word;
    ram_wdata       = '0;
    ram_raddr       = word;
    emit            = 1'b0;
    emit_status     = ST_OK;
    emit_value      = '0;
    emit_last       = 1'b1;

    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        word_next = word + AW'(1);
      end
      S_IDLE: begin
        ram_raddr       = '0;
        word_next       = '0;
        run_next        = '0;
        avail_next      = '0;
        res_status_next = ST_OK;
        res_value_next  = '0;
        if (in_accept) begin
          if ((in_op == OP_SET) || (in_op == OP_CLEAR)) begin
            ram_raddr      = AW'(in_index[INDEX_W-1:BIT_W]);
            res_value_next = in_index;
          end else if ((in_op == OP_RESERVE) && (in_count > COUNT_W'(MAX_RESERVE))) begin
            res_status_next = ST_TOO_LARGE;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = word + AW'(1);
        word_next = word + AW'(1);
        if (op_r == OP_FIND) begin
          run_next = scan_run;
          if (scan_found) begin
            res_value_next = VALUE_W'(scan_base);
          end else if (word == LAST_WORD) begin
            res_status_next = ST_NO_SPACE;
          end
        end else begin
          avail_next = avail_sum;
          if (avail_sum >= count_r) begin
            word_next      = '0;
            remaining_next = RW'(count_r);
          end else if (word == LAST_WORD) begin
            res_status_next = ST_NO_SPACE;
          end
        end
      end
      S_RES_RD: begin
        ram_raddr = word;
      end
      S_RES_LOAD: begin
        cur_next = ram_rdata;
      end
      S_RES_EMIT: begin
        if ((remaining == '0) || (cur_free == '0)) begin
          // Word exhausted or request complete: write the word back.
          ram_we    = 1'b1;
          ram_waddr = word;
          ram_wdata = cur;
          word_next = word + AW'(1);
        end else if (out_free) begin
          emit             = 1'b1;
          emit_value       = VALUE_W'(word_base + COUNT_W'(cur_sel));
          emit_last        = (remaining == RW'(1));
          cur_next         = cur | (WORD_W'(1) << cur_sel);
          remaining_next   = remaining - RW'(1);
        end
      end
      S_SETCLR: begin
        ram_we    = idx_active;
        ram_waddr = idx_word;
        ram_wdata = ram_rdata;
        ram_wdata[idx_r[BIT_W-1:0]] = (op_r == OP_SET);
      end
      S_REPLY: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = res_status;
          emit_value  = res_value;
          emit_last   = 1'b1;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      word      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      word      <= word_next;
      out_valid <= emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    run        <= run_next;
    avail      <= avail_next;
    remaining  <= remaining_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (in_accept) begin
      op_r    <= in_op;
      count_r <= in_count;
      idx_r   <= in_index;
    end
    if (emit) begin
      out_status <= emit_status;
      out_value  <= emit_value;
      out_last   <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_value, out_status};
  assign m_axis_tlast  = out_last;

endmodule
